// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the formatter RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("%m: invariant violated");

// Check that a consequent holds in the cycle of its antecedent.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("%m: implication violated");

// Check that a consequent holds in the cycle after its antecedent.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("%m: next-cycle implication violated");

`endif

// ===== src/fsi_pkg.sv =====
// ----------------------------------------------------------------------------
// fsi_pkg
// Types, constants and helpers shared by the integer formatter modules.
// ----------------------------------------------------------------------------
package fsi_pkg;

    localparam int unsigned ARG_W    = 32;
    localparam int unsigned CHAR_W   = 8;
    // fmt_char and arg_value packed, filled up to whole bytes
    localparam int unsigned IN_W     = ((CHAR_W + ARG_W + 7) / 8) * 8;
    localparam int unsigned OUT_W    = 8;

    // Most digits a value can produce (octal is the longest).
    localparam int unsigned DEPTH    = (ARG_W + 2) / 3;
    localparam int unsigned CNT_W    = $clog2(DEPTH + 1);

    // Reciprocal of ten: floor(v / 10) == (v * RECIP10) >> RECIP_SH for any ARG_W-bit v.
    localparam int unsigned RECIP_SH = ARG_W + 4;
    localparam logic [ARG_W:0] RECIP10 =
        (ARG_W + 1)'(((72'd1 << RECIP_SH) + 72'd9) / 72'd10);
    localparam int unsigned PROD_W   = 2 * ARG_W + 1;

    // Characters
    localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;
    localparam logic [CHAR_W-1:0] CH_PERCENT = 8'h25;
    localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2d;
    localparam logic [CHAR_W-1:0] CH_LOW_C   = 8'h63;
    localparam logic [CHAR_W-1:0] CH_LOW_D   = 8'h64;
    localparam logic [CHAR_W-1:0] CH_LOW_I   = 8'h69;
    localparam logic [CHAR_W-1:0] CH_LOW_U   = 8'h75;
    localparam logic [CHAR_W-1:0] CH_LOW_O   = 8'h6f;
    localparam logic [CHAR_W-1:0] CH_LOW_X   = 8'h78;
    localparam logic [CHAR_W-1:0] CH_UP_X    = 8'h58;
    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
    // 'a' minus ten, so digit value ten maps onto 'a'
    localparam logic [CHAR_W-1:0] CH_HEX_OFS = 8'h57;

    typedef enum logic [1:0] {
        BASE_DEC,
        BASE_OCT,
        BASE_HEX
    } fsi_base_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIGITS,
        ST_OUT
    } fsi_state_t;

    typedef struct packed {
        logic             load;
        logic             step;
        fsi_base_t        base;
        logic [ARG_W-1:0] value;
    } fsi_ctrl_t;

    typedef struct packed {
        logic       dig_valid;
        logic [3:0] digit;
        logic       final_dig;
    } fsi_stat_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
        logic [CHAR_W-1:0] ch;
        if (d < 4'd10) begin
            ch = CH_ZERO + {4'h0, d};
        end else begin
            ch = CH_HEX_OFS + {4'h0, d};
        end
        return ch;
    endfunction

endpackage

// ===== src/fsi_digit_unit.sv =====
// ----------------------------------------------------------------------------
// fsi_digit_unit
// Shared digit extractor: peels the least significant digit off a value, by
// shift for octal and hex on each step, by reciprocal multiply for decimal.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fsi_digit_unit (
    input  logic              aclk,
    input  logic              aresetn,
    input  fsi_pkg::fsi_ctrl_t ctrl,
    output fsi_pkg::fsi_stat_t stat
);
    import fsi_pkg::*;

    logic [ARG_W-1:0]  val_reg;
    logic [ARG_W-1:0]  val_next;
    fsi_base_t         base_reg;
    logic              phase_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [ARG_W-1:0]  quot;
    logic [3:0]        q_times10;
    logic [3:0]        dec_rem;
    logic [3:0]        digit;

    // Decimal runs in two phases: multiply, then take quotient and remainder
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= 1'b0;
        end else if (ctrl.load) begin
            phase_reg <= 1'b0;
        end else if (ctrl.step && base_reg == BASE_DEC) begin
            phase_reg <= ~phase_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            val_reg  <= ctrl.value;
            base_reg <= ctrl.base;
        end else if (stat.dig_valid) begin
            val_reg  <= val_next;
        end
        if (ctrl.step && base_reg == BASE_DEC && !phase_reg) begin
            prod_reg <= PROD_W'(val_reg) * PROD_W'(RECIP10);
        end
    end

    always_comb begin
        quot      = ARG_W'(prod_reg[PROD_W-1:RECIP_SH]);
        // low nibble of quot * 10 is enough, the remainder is below ten
        q_times10 = {quot[0], 3'b000} + {quot[2:0], 1'b0};
        dec_rem   = val_reg[3:0] - q_times10;
        case (base_reg)
            BASE_DEC: begin
                digit    = dec_rem;
                val_next = quot;
            end
            BASE_OCT: begin
                digit    = {1'b0, val_reg[2:0]};
                val_next = val_reg >> 3;
            end
            BASE_HEX: begin
                digit    = val_reg[3:0];
                val_next = val_reg >> 4;
            end
            default: begin
                digit    = val_reg[3:0];
                val_next = '0;
            end
        endcase
        stat.dig_valid = ctrl.step && (base_reg != BASE_DEC || phase_reg);
        stat.digit     = digit;
        stat.final_dig = (val_next == '0);
    end

    `ASSERT_IMPL(a_dec_digit_range, aclk, aresetn, stat.dig_valid && base_reg == BASE_DEC, digit < 4'd10)
    `ASSERT_IMPL(a_oct_digit_range, aclk, aresetn, stat.dig_valid && base_reg == BASE_OCT, digit < 4'd8)
    `ASSERT_NEXT(a_dec_phase_flip, aclk, aresetn, ctrl.step && !ctrl.load && base_reg == BASE_DEC && !phase_reg, phase_reg)

endmodule

// ===== src/format_string_integer_formatter_core.sv =====
// ----------------------------------------------------------------------------
// format_string_integer_formatter_core
// Streaming printf-style formatter: echoes format characters and renders
// %c %d %i %u %o %x %X %% from the argument word of the same input word.
//
//   channel | dir | tdata                                 | tlast
//   s_      | in  | [7:0] fmt_char, [39:8] arg_value       | -
//   m_      | out | [7:0] out_char                        | last_char
//
// A plain character or %c / %% passes straight into the output register.
// A number is split into digits in the shared digit unit (shift for octal and
// hex, multiply then remainder for decimal), then sent out one character at a
// time, any minus sign first, while m_tready low stalls the output.
// s_tready is high only in idle with the output register free or draining.
// Reset (aresetn low, synchronous) clears the percent flag, state and m_tvalid.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module format_string_integer_formatter_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [fsi_pkg::IN_W-1:0]    s_tdata,   // [7:0] fmt_char, [39:8] arg_value
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [fsi_pkg::OUT_W-1:0]   m_tdata,   // [7:0] out_char
    output logic                        m_tlast    // last_char
);
    import fsi_pkg::*;

    fsi_state_t              state_reg, state_next;
    logic                    after_pct_reg, after_pct_next;
    logic                    sign_reg, sign_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [DEPTH-1:0][3:0]   stk_reg, stk_next;
    logic                    out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]       out_char_reg, out_char_next;
    logic                    out_last_reg, out_last_next;

    fsi_ctrl_t               ctrl;
    fsi_stat_t               stat;

    logic [CHAR_W-1:0]       fmt;
    logic [ARG_W-1:0]        arg;
    logic                    accept;
    logic                    out_free;

    // decode of the incoming word
    logic                    dec_emit;
    logic [CHAR_W-1:0]       dec_char;
    logic                    dec_num;
    fsi_base_t               dec_base;
    logic                    dec_neg;
    logic                    dec_after;

    fsi_digit_unit u_digit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .stat    (stat)
    );

    assign fmt      = s_tdata[CHAR_W-1:0];
    assign arg      = s_tdata[CHAR_W +: ARG_W];
    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        dec_emit  = 1'b0;
        dec_char  = fmt;
        dec_num   = 1'b0;
        dec_base  = BASE_DEC;
        dec_neg   = 1'b0;
        dec_after = 1'b0;
        if (fmt == CH_NUL) begin
            dec_after = 1'b0;
        end else if (!after_pct_reg) begin
            if (fmt == CH_PERCENT) begin
                dec_after = 1'b1;
            end else begin
                dec_emit = 1'b1;
            end
        end else begin
            case (fmt)
                CH_LOW_C: begin
                    dec_emit = 1'b1;
                    dec_char = arg[CHAR_W-1:0];
                end
                CH_PERCENT: begin
                    dec_emit = 1'b1;
                    dec_char = CH_PERCENT;
                end
                CH_LOW_D, CH_LOW_I: begin
                    dec_num = 1'b1;
                    dec_neg = arg[ARG_W-1];
                end
                CH_LOW_U: begin
                    dec_num = 1'b1;
                end
                CH_LOW_O: begin
                    dec_num  = 1'b1;
                    dec_base = BASE_OCT;
                end
                CH_LOW_X, CH_UP_X: begin
                    dec_num  = 1'b1;
                    dec_base = BASE_HEX;
                end
                default: begin
                    dec_emit = 1'b0;
                end
            endcase
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && dec_num) begin
                    state_next = ST_DIGITS;
                end
            end
            ST_DIGITS: begin
                if (stat.dig_valid && stat.final_dig) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free && !sign_reg && cnt_reg == CNT_W'(1)) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        after_pct_next = after_pct_reg;
        sign_next      = sign_reg;
        cnt_next       = cnt_reg;
        stk_next       = stk_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        ctrl.load      = 1'b0;
        ctrl.step      = 1'b0;
        ctrl.base      = dec_base;
        ctrl.value     = dec_neg ? (ARG_W'(0) - arg) : arg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    after_pct_next = dec_after;
                    sign_next      = dec_neg;
                    cnt_next       = '0;
                    ctrl.load      = dec_num;
                    if (dec_emit) begin
                        out_valid_next = 1'b1;
                        out_char_next  = dec_char;
                        out_last_next  = 1'b1;
                    end
                end
            end
            ST_DIGITS: begin
                ctrl.step = 1'b1;
                if (stat.dig_valid) begin
                    // push: newest digit is the most significant so far
                    stk_next = {stk_reg[DEPTH-2:0], stat.digit};
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    if (sign_reg) begin
                        out_char_next = CH_MINUS;
                        out_last_next = 1'b0;
                        sign_next     = 1'b0;
                    end else begin
                        out_char_next = digit_char(stk_reg[0]);
                        out_last_next = (cnt_reg == CNT_W'(1));
                        stk_next      = {4'h0, stk_reg[DEPTH-1:1]};
                        cnt_next      = cnt_reg - CNT_W'(1);
                    end
                end
            end
            default: begin
                ctrl.step = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            after_pct_reg <= 1'b0;
            sign_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            after_pct_reg <= after_pct_next;
            sign_reg      <= sign_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        stk_reg      <= stk_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_char_reg;
    assign m_tlast  = out_last_reg;

    `ASSERT_ALWAYS(a_cnt_bound, aclk, aresetn, cnt_reg <= CNT_W'(DEPTH))
    `ASSERT_IMPL(a_out_nonempty, aclk, aresetn, state_reg == ST_OUT, cnt_reg != '0)
    `ASSERT_IMPL(a_push_in_digits, aclk, aresetn, stat.dig_valid, state_reg == ST_DIGITS)

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// Integer formatter core testbench
// Streams format characters with argument words into the core and checks
// every emitted character and its end-of-item flag against a predicted
// stream. Directed corner cases come first, then random well-formed
// specifier sequences mixed with noise, under several idle and stall mixes.
// One long receiver hold-off fills the core and backs up its input.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import fsi_pkg::*;

    localparam int CLK_HALF   = 5;
    localparam int CYCLE_CAP  = 300000;
    localparam int HOLD_LEN   = 400;
    localparam int PHASE_LEN  = 48;
    localparam int TAIL_WAIT  = 64;

    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } emitted_t;

    // Predicts the character stream and checks what the core sends out.
    class char_scoreboard;
        emitted_t          expected_chars[$];
        logic [CHAR_W-1:0] item_chars[$];
        bit                pct_armed;
        int                errors;

        function new();
            pct_armed = 1'b0;
            errors    = 0;
        endfunction

        function void add_digits(logic [ARG_W-1:0] v, int unsigned radix);
            logic [CHAR_W-1:0] digs[$];
            logic [ARG_W-1:0]  d;
            do begin
                d = v % radix;
                if (d < 10)
                    digs.push_front(CH_ZERO + d[7:0]);
                else
                    digs.push_front(8'h61 + d[7:0] - 8'd10);
                v = v / radix;
            end while (v != 0);
            foreach (digs[k]) item_chars.push_back(digs[k]);
        endfunction

        function void note_format_char(logic [CHAR_W-1:0] fmt, logic [ARG_W-1:0] arg);
            emitted_t e;
            item_chars.delete();
            if (fmt == CH_NUL) begin
                pct_armed = 1'b0;
            end else if (!pct_armed) begin
                if (fmt == CH_PERCENT)
                    pct_armed = 1'b1;
                else
                    item_chars.push_back(fmt);
            end else begin
                pct_armed = 1'b0;
                case (fmt)
                    CH_LOW_C: item_chars.push_back(arg[7:0]);
                    CH_LOW_D, CH_LOW_I: begin
                        if (arg[ARG_W-1]) begin
                            item_chars.push_back(CH_MINUS);
                            arg = -arg;
                        end
                        add_digits(arg, 10);
                    end
                    CH_LOW_U: add_digits(arg, 10);
                    CH_LOW_O: add_digits(arg, 8);
                    CH_LOW_X, CH_UP_X: add_digits(arg, 16);
                    CH_PERCENT: item_chars.push_back(CH_PERCENT);
                    default: ;
                endcase
            end
            foreach (item_chars[k]) begin
                e.ch   = item_chars[k];
                e.last = (k == item_chars.size() - 1);
                expected_chars.push_back(e);
            end
        endfunction

        function void check_out_char(logic [CHAR_W-1:0] ch, logic last);
            emitted_t e;
            if (expected_chars.size() == 0) begin
                $error("unexpected word: out_char %h last_char %b", ch, last);
                errors++;
            end else begin
                e = expected_chars.pop_front();
                if (ch !== e.ch) begin
                    $error("out_char: expected %h, actual %h", e.ch, ch);
                    errors++;
                end
                if (last !== e.last) begin
                    $error("last_char: expected %b, actual %b", e.last, last);
                    errors++;
                end
            end
        endfunction

        function int pending_count();
            return expected_chars.size();
        endfunction
    endclass

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata  = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;
    logic              m_tlast;

    char_scoreboard    sb;
    int                send_idle_pct  = 0;
    int                recv_stall_pct = 0;
    bit                hold_req       = 1'b0;
    int                hold_left      = 0;
    int                cycle_count    = 0;
    logic [CHAR_W-1:0] spec_codes[8];

    format_string_integer_formatter_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #CLK_HALF aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_CAP) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Offer one word; return at the edge that accepts it.
    task automatic send_word(input logic [CHAR_W-1:0] fmt, input logic [ARG_W-1:0] arg);
        bit taken;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {arg, fmt};
        do begin
            // inputs only move at the rising edge, so the negedge view holds
            @(negedge aclk);
            taken = s_tready;
            if (taken)
                sb.note_format_char(fmt, arg);
            @(posedge aclk);
        end while (!taken);
    endtask

    task automatic send_spec(input logic [CHAR_W-1:0] spec, input logic [ARG_W-1:0] arg);
        send_word(CH_PERCENT, $urandom);
        send_word(spec, arg);
    endtask

    function automatic logic [ARG_W-1:0] pick_arg();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 32'h8000_0000;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h7FFF_FFFF;
            4, 5:    return $urandom_range(0, 99);
            6:       return $urandom_range(0, 65535);
            default: return $urandom;
        endcase
    endfunction

    function automatic bit is_known_spec(logic [CHAR_W-1:0] c);
        foreach (spec_codes[k])
            if (spec_codes[k] == c) return 1'b1;
        return 1'b0;
    endfunction

    // Receiver: check accepted words, stall at random, hold off on request.
    initial begin
        forever begin
            @(negedge aclk);
            if (aresetn && m_tvalid && m_tready)
                sb.check_out_char(m_tdata[CHAR_W-1:0], m_tlast);
            @(posedge aclk);
            if (hold_left == 0 && hold_req) begin
                hold_left = HOLD_LEN;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    initial begin
        int                sent;
        int                kind;
        logic [CHAR_W-1:0] junk;

        sb = new();
        spec_codes = '{CH_LOW_C, CH_LOW_D, CH_LOW_I, CH_LOW_U,
                       CH_LOW_O, CH_LOW_X, CH_UP_X, CH_PERCENT};
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // directed corners
        send_word(8'h01, 32'hFFFF_FFFF);
        send_word(8'hFF, '0);
        send_word(8'h48, 32'h1234_5678);
        send_spec(CH_LOW_D, '0);
        send_spec(CH_LOW_D, 32'h8000_0000);
        send_spec(CH_LOW_D, 32'h7FFF_FFFF);
        send_spec(CH_LOW_I, 32'hFFFF_FFFF);
        send_spec(CH_LOW_U, 32'hFFFF_FFFF);
        send_spec(CH_LOW_O, 32'hFFFF_FFFF);
        send_spec(CH_LOW_X, 32'hFFFF_FFFF);
        send_spec(CH_UP_X, 32'h0000_ABCD);
        send_spec(CH_LOW_C, 32'hFFFF_FF7A);
        send_spec(CH_PERCENT, 32'hFFFF_FFFF);
        send_spec(8'h71, 32'h0000_0001);
        send_spec(CH_NUL, 32'h0000_0005);
        send_word(CH_NUL, '0);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  hold_req = 1'b1; end
                1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
                default: begin send_idle_pct = 10; recv_stall_pct = 10; end
            endcase
            sent = 0;
            while (sent < PHASE_LEN) begin
                kind = $urandom_range(0, 99);
                if (kind < 45) begin
                    send_spec(spec_codes[$urandom_range(0, 7)], pick_arg());
                    sent += 2;
                end else if (kind < 55) begin
                    do junk = CHAR_W'($urandom_range(1, 255));
                    while (is_known_spec(junk));
                    send_spec(junk, $urandom);
                    sent += 2;
                end else if (kind < 61) begin
                    send_spec(CH_NUL, $urandom);
                    sent += 2;
                end else if (kind < 66) begin
                    send_word(CH_NUL, $urandom);
                    sent++;
                end else begin
                    send_word(CHAR_W'($urandom_range(1, 255)), $urandom);
                    sent++;
                end
            end
        end
        s_tvalid <= 1'b0;

        while (sb.pending_count() != 0) @(posedge aclk);
        repeat (TAIL_WAIT) @(posedge aclk);
        if (sb.pending_count() != 0) begin
            $error("%0d expected words never arrived", sb.pending_count());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/fsi_pkg.sv
src/fsi_digit_unit.sv
src/format_string_integer_formatter_core.sv
dv/testbench.sv
